>>> rtl/core/bpj_pkg.sv
// ----------------------------------------------------------------------------
// bpj_pkg
// Shared types, constants and helpers for the depth pixel back-projection core.
// ----------------------------------------------------------------------------
package bpj_pkg;

    localparam int MAX_IMAGE_DIM_DEF = 4096;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_DEPTH_SCALE = 3'd0;
    localparam logic [2:0] REG_FOCAL_X     = 3'd1;
    localparam logic [2:0] REG_FOCAL_Y     = 3'd2;
    localparam logic [2:0] REG_CENTER_X    = 3'd3;
    localparam logic [2:0] REG_CENTER_Y    = 3'd4;

    localparam logic [15:0] RST_DEPTH_SCALE = 16'd1000;
    localparam logic [15:0] RST_FOCAL_X     = 16'd8288;
    localparam logic [15:0] RST_FOCAL_Y     = 16'd8112;
    localparam logic [15:0] RST_CENTER_X    = 16'd5208;
    localparam logic [15:0] RST_CENTER_Y    = 16'd4056;

    localparam int QBITS = 33;   // quotient bits 32..0
    localparam int NLANE = 3;    // x, y, z
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    typedef struct packed {
        logic [47:0]      rem;
        logic [31:0]      den;
        logic [QBITS-1:0] quo;
        logic             ovf;
        logic             neg;
    } t_lane;

    typedef struct packed {
        t_lane [NLANE-1:0] lane;
        logic [23:0]       rgb;   // blue, green, red from the lowest bit up
    } t_stage;

    // Signed 32-bit saturation of a sign/magnitude quotient
    function automatic logic [31:0] sat_lateral(input t_lane l);
        logic [31:0] res;
        if (l.neg) begin
            if (l.ovf || l.quo[32] || l.quo[31]) begin
                res = 32'h8000_0000;
            end else begin
                res = 32'(-l.quo[31:0]);
            end
        end else begin
            if (l.ovf || l.quo[32] || l.quo[31]) begin
                res = 32'h7FFF_FFFF;
            end else begin
                res = l.quo[31:0];
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/core/bpj_front.sv
// ----------------------------------------------------------------------------
// bpj_front
// Three-stage front end: pixel offset, products, divider setup.
// ----------------------------------------------------------------------------
module bpj_front #(
    parameter int MAX_IMAGE_DIM = bpj_pkg::MAX_IMAGE_DIM_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [2:0]         i_en,
    input  logic               i_vld,
    input  logic [63:0]        i_tdata,
    input  logic [15:0]        i_depth_scale,
    input  logic [15:0]        i_focal_x,
    input  logic [15:0]        i_focal_y,
    input  logic [15:0]        i_center_x,
    input  logic [15:0]        i_center_y,
    output logic [2:0]         o_vld,
    output bpj_pkg::t_stage    o_stage
);

    localparam logic [16:0] IDX_LIM = 17'(MAX_IMAGE_DIM - 1);

    logic [11:0] row_c, col_c;
    logic [15:0] p16x, p16y;

    // stage 1
    logic [2:0]  r_vld;
    logic [15:0] r_magx, r_magy, r_d1, r_s1, r_fx, r_fy;
    logic        r_negx1, r_negy1;
    logic [23:0] r_rgb1;
    // stage 2
    logic [31:0] r_numx, r_numy, r_denx, r_deny;
    logic [15:0] r_d2, r_s2;
    logic        r_negx2, r_negy2;
    logic [23:0] r_rgb2;
    // stage 3
    bpj_pkg::t_stage r_stage;
    bpj_pkg::t_stage n_stage;

    always_comb begin
        row_c = ({5'b0, i_tdata[11:0]}  > IDX_LIM) ? IDX_LIM[11:0] : i_tdata[11:0];
        col_c = ({5'b0, i_tdata[23:12]} > IDX_LIM) ? IDX_LIM[11:0] : i_tdata[23:12];
        p16x  = {col_c, 4'b0};
        p16y  = {row_c, 4'b0};
    end

    always_comb begin
        n_stage = '0;
        n_stage.rgb = r_rgb2;
        n_stage.lane[bpj_pkg::LANE_X].rem = {r_numx, 16'b0};
        n_stage.lane[bpj_pkg::LANE_X].den = r_denx;
        n_stage.lane[bpj_pkg::LANE_X].ovf = ({17'b0, r_numx[31:17]} >= r_denx);
        n_stage.lane[bpj_pkg::LANE_X].neg = r_negx2;
        n_stage.lane[bpj_pkg::LANE_Y].rem = {r_numy, 16'b0};
        n_stage.lane[bpj_pkg::LANE_Y].den = r_deny;
        n_stage.lane[bpj_pkg::LANE_Y].ovf = ({17'b0, r_numy[31:17]} >= r_deny);
        n_stage.lane[bpj_pkg::LANE_Y].neg = r_negy2;
        n_stage.lane[bpj_pkg::LANE_Z].rem = {16'b0, r_d2, 16'b0};
        n_stage.lane[bpj_pkg::LANE_Z].den = {16'b0, r_s2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (i_en[0]) r_vld[0] <= i_vld;
            if (i_en[1]) r_vld[1] <= r_vld[0];
            if (i_en[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_negx1 <= p16x < i_center_x;
            r_magx  <= (p16x < i_center_x) ? i_center_x - p16x : p16x - i_center_x;
            r_negy1 <= p16y < i_center_y;
            r_magy  <= (p16y < i_center_y) ? i_center_y - p16y : p16y - i_center_y;
            r_d1    <= i_tdata[39:24];
            r_s1    <= (i_depth_scale == 16'd0) ? 16'd1 : i_depth_scale;
            r_fx    <= (i_focal_x == 16'd0) ? 16'd1 : i_focal_x;
            r_fy    <= (i_focal_y == 16'd0) ? 16'd1 : i_focal_y;
            r_rgb1  <= i_tdata[63:40];
        end
        if (i_en[1]) begin
            r_numx  <= r_magx * r_d1;
            r_numy  <= r_magy * r_d1;
            r_denx  <= r_s1 * r_fx;
            r_deny  <= r_s1 * r_fy;
            r_d2    <= r_d1;
            r_s2    <= r_s1;
            r_negx2 <= r_negx1;
            r_negy2 <= r_negy1;
            r_rgb2  <= r_rgb1;
        end
        if (i_en[2]) begin
            r_stage <= n_stage;
        end
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

endmodule

>>> rtl/core/bpj_div_stage.sv
// ----------------------------------------------------------------------------
// bpj_div_stage
// One restoring division step on all three lanes, quotient bit BIT.
// ----------------------------------------------------------------------------
module bpj_div_stage #(
    parameter int BIT = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  bpj_pkg::t_stage i_stage,
    output logic            o_vld,
    output bpj_pkg::t_stage o_stage
);

    logic            r_vld;
    bpj_pkg::t_stage r_stage;
    bpj_pkg::t_stage n_stage;

    always_comb begin
        logic [65:0] shifted;
        logic [65:0] diff;
        n_stage = i_stage;
        for (int i = 0; i < bpj_pkg::NLANE; i++) begin
            shifted = 66'(i_stage.lane[i].den) << BIT;
            diff    = {18'b0, i_stage.lane[i].rem} - shifted;
            // keep the remainder when the trial subtract borrows
            n_stage.lane[i].quo[BIT] = ~diff[65];
            if (!diff[65]) begin
                n_stage.lane[i].rem = diff[47:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

endmodule

>>> rtl/core/depth_pixel_backprojection_core.sv
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_core
// Pinhole back-projection of depth pixels into colored Q16.16 3D points.
//
// channel | direction | transfer fields (lowest bit up)
// --------+-----------+----------------------------------------------------
// s       | in        | tdata: pixel_row, pixel_column, raw_depth, b, g, r
// m       | out       | tdata: point_x, point_y, point_z, b, g, r
// cfg     | in        | index (0..4), data[15:0]
//
// One pixel per cycle unless the output stalls. Stages: 3 front stages
// (offset, multiply, divider setup), 33 restoring divider stages (one
// quotient bit each), and the saturating output register.
// Pixels with zero depth are dropped at the first stage.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles collapse during a stall. Synchronous active-low reset clears the
// valid bits and restores the register defaults.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_core #(
    parameter int MAX_IMAGE_DIM = bpj_pkg::MAX_IMAGE_DIM_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [63:0]  i_s_tdata,   // row[11:0], column[23:12], depth[39:24],
                                      // blue[47:40], green[55:48], red[63:56]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [119:0] o_m_tdata,   // x[31:0], y[63:32], z[95:64],
                                      // blue[103:96], green[111:104], red[119:112]
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    localparam int NDIV = bpj_pkg::QBITS;
    localparam int NSTG = 3 + NDIV + 1;

    logic [15:0] r_depth_scale, r_focal_x, r_focal_y, r_center_x, r_center_y;

    logic [NSTG-1:0] vld;
    logic [NSTG-1:0] en;
    bpj_pkg::t_stage div_stage [0:NDIV];

    logic            r_out_vld;
    logic [119:0]    r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_scale <= bpj_pkg::RST_DEPTH_SCALE;
            r_focal_x     <= bpj_pkg::RST_FOCAL_X;
            r_focal_y     <= bpj_pkg::RST_FOCAL_Y;
            r_center_x    <= bpj_pkg::RST_CENTER_X;
            r_center_y    <= bpj_pkg::RST_CENTER_Y;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bpj_pkg::REG_DEPTH_SCALE: r_depth_scale <= i_cfg_data;
                bpj_pkg::REG_FOCAL_X:     r_focal_x     <= i_cfg_data;
                bpj_pkg::REG_FOCAL_Y:     r_focal_y     <= i_cfg_data;
                bpj_pkg::REG_CENTER_X:    r_center_x    <= i_cfg_data;
                bpj_pkg::REG_CENTER_Y:    r_center_y    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        en[NSTG-1] = !vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[0];

    bpj_front #(
        .MAX_IMAGE_DIM(MAX_IMAGE_DIM)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en[2:0]),
        .i_vld         (i_s_tvalid && (i_s_tdata[39:24] != 16'd0)),
        .i_tdata       (i_s_tdata),
        .i_depth_scale (r_depth_scale),
        .i_focal_x     (r_focal_x),
        .i_focal_y     (r_focal_y),
        .i_center_x    (r_center_x),
        .i_center_y    (r_center_y),
        .o_vld         (vld[2:0]),
        .o_stage       (div_stage[0])
    );

    for (genvar j = 0; j < NDIV; j++) begin : g_div
        bpj_div_stage #(
            .BIT(NDIV - 1 - j)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[3+j]),
            .i_vld   (vld[2+j]),
            .i_stage (div_stage[j]),
            .o_vld   (vld[3+j]),
            .o_stage (div_stage[j+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en[NSTG-1]) begin
            r_out_vld <= vld[NSTG-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NSTG-1]) begin
            r_out_data <= {
                div_stage[NDIV].rgb,
                div_stage[NDIV].lane[bpj_pkg::LANE_Z].quo[31:0],
                bpj_pkg::sat_lateral(div_stage[NDIV].lane[bpj_pkg::LANE_Y]),
                bpj_pkg::sat_lateral(div_stage[NDIV].lane[bpj_pkg::LANE_X])
            };
        end
    end

    assign vld[NSTG-1] = r_out_vld;
    assign o_m_tvalid  = r_out_vld;
    assign o_m_tdata   = r_out_data;

    // An empty entry stage always takes a transfer
    a_entry_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !vld[0] |-> o_s_tready)
        else $error("entry stage empty but input not ready");

    // A zero-depth pixel never enters the pipeline
    a_zero_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tdata[39:24] == 16'd0)) |=> !vld[0])
        else $error("zero-depth pixel entered the pipeline");

    // A positive overflow on x saturates to the largest value
    a_sat_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (vld[NSTG-2] && en[NSTG-1] && div_stage[NDIV].lane[bpj_pkg::LANE_X].ovf &&
         !div_stage[NDIV].lane[bpj_pkg::LANE_X].neg)
        |=> (o_m_tdata[31:0] == 32'h7FFF_FFFF))
        else $error("x overflow not saturated");

endmodule

>>> tb/sv/depth_pixel_backprojection_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_core_tb
// Streams pixels through the back-projection core under several idle and
// stall phases and register settings, predicts each 3D point in the bench
// and compares every output transfer field by field in order.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_core_tb;

    localparam int  LATENCY     = 37;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam real HALF_PERIOD = 2.0;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] depth;
        logic [11:0] column;
        logic [11:0] row;
    } t_pixel;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } t_point;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic [63:0]  i_s_tdata = '0;
    logic         i_m_tready = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [15:0]  i_cfg_data = '0;
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic [119:0] o_m_tdata;
    logic         o_cfg_ready;

    depth_pixel_backprojection_core dut (.*);

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // predictor copy of the registers
    logic [15:0] scale_reg, fx_reg, fy_reg, cx_reg, cy_reg;

    t_pixel pixel_q[$];
    t_point point_q[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     errors = 0;
    int     cycles = 0;

    function automatic logic [31:0] lateral_coord(logic [11:0] pix, logic [15:0] ctr,
                                                  logic [15:0] d, logic [31:0] den);
        logic [63:0] p16, mag, q;
        p16 = {52'd0, pix} * 64'd16;
        if (p16 < {48'd0, ctr}) begin
            mag = {48'd0, ctr} - p16;
            q = (mag * {48'd0, d} * 64'd65536) / {32'd0, den};
            return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        end
        mag = p16 - {48'd0, ctr};
        q = (mag * {48'd0, d} * 64'd65536) / {32'd0, den};
        return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    task automatic queue_pixel(t_pixel p);
        t_point r;
        logic [31:0] s, fx, fy;
        pixel_q.insert(pixel_q.size(), p);
        if (p.depth == 16'd0) return;
        s  = (scale_reg == 16'd0) ? 32'd1 : {16'd0, scale_reg};
        fx = (fx_reg == 16'd0) ? 32'd1 : {16'd0, fx_reg};
        fy = (fy_reg == 16'd0) ? 32'd1 : {16'd0, fy_reg};
        r.x = lateral_coord(p.column, cx_reg, p.depth, s * fx);
        r.y = lateral_coord(p.row, cy_reg, p.depth, s * fy);
        r.z = 32'(({48'd0, p.depth} * 64'd65536) / {32'd0, s});
        r.blue = p.blue;
        r.green = p.green;
        r.red = p.red;
        point_q.insert(point_q.size(), r);
    endtask

    // pixel driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_tvalid || o_s_tready) begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pixel_q.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // point monitor
    always @(posedge i_clk) begin
        t_point got, want;
        cycles <= cycles + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (point_q.size() == 0) begin
                $display("%0t: unexpected point %h", $time, got);
                errors <= errors + 1;
            end else begin
                want = point_q.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z
                    || got.blue !== want.blue || got.green !== want.green
                    || got.red !== want.red) begin
                    $display("%0t: point mismatch expected x=%h y=%h z=%h bgr=%h%h%h",
                             $time, want.x, want.y, want.z, want.blue, want.green,
                             want.red);
                    $display("%0t:                actual   x=%h y=%h z=%h bgr=%h%h%h",
                             $time, got.x, got.y, got.z, got.blue, got.green, got.red);
                    errors <= errors + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            bpj_pkg::REG_DEPTH_SCALE: scale_reg = val;
            bpj_pkg::REG_FOCAL_X:     fx_reg = val;
            bpj_pkg::REG_FOCAL_Y:     fy_reg = val;
            bpj_pkg::REG_CENTER_X:    cx_reg = val;
            bpj_pkg::REG_CENTER_Y:    cy_reg = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pixel_q.size() == 0 && point_q.size() == 0 && !i_s_tvalid);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic t_pixel rand_pixel(bit allow_zero);
        t_pixel p;
        p = {$urandom, $urandom};
        case ($urandom_range(3))
            0: p.depth = 16'($urandom_range(1, 4000));
            1: p.depth = 16'($urandom_range(1, 65535));
            default: ;
        endcase
        if (!allow_zero && p.depth == 16'd0) p.depth = 16'd1;
        return p;
    endfunction

    initial begin
        scale_reg = bpj_pkg::RST_DEPTH_SCALE;
        fx_reg = bpj_pkg::RST_FOCAL_X;
        fy_reg = bpj_pkg::RST_FOCAL_Y;
        cx_reg = bpj_pkg::RST_CENTER_X;
        cy_reg = bpj_pkg::RST_CENTER_Y;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero depth, colors, reset registers
        queue_pixel('{red: 8'hFF, green: 8'h00, blue: 8'hA5, depth: 16'd1000,
                      column: 12'd0, row: 12'd0});
        queue_pixel('{red: 8'h00, green: 8'hFF, blue: 8'h5A, depth: 16'hFFFF,
                      column: 12'hFFF, row: 12'hFFF});
        queue_pixel('{red: 8'h12, green: 8'h34, blue: 8'h56, depth: 16'd0,
                      column: 12'd100, row: 12'd100});
        queue_pixel('{red: 8'h01, green: 8'h02, blue: 8'h03, depth: 16'd1,
                      column: 12'd325, row: 12'd253});
        queue_pixel('{red: 8'h80, green: 8'h7F, blue: 8'hFF, depth: 16'd500,
                      column: 12'd326, row: 12'd254});
        drain();

        // zero scale and focal lengths taken as one: saturation both ways
        write_reg(bpj_pkg::REG_DEPTH_SCALE, 16'd0);
        write_reg(bpj_pkg::REG_FOCAL_X, 16'd0);
        write_reg(bpj_pkg::REG_FOCAL_Y, 16'd0);
        write_reg(bpj_pkg::REG_CENTER_X, 16'hFFFF);
        write_reg(bpj_pkg::REG_CENTER_Y, 16'd0);
        write_reg(3'd7, 16'h1234);
        queue_pixel('{red: 8'd9, green: 8'd8, blue: 8'd7, depth: 16'hFFFF,
                      column: 12'd0, row: 12'hFFF});
        queue_pixel('{red: 8'd1, green: 8'd1, blue: 8'd1, depth: 16'd1,
                      column: 12'hFFF, row: 12'd0});
        queue_pixel('{red: 8'd2, green: 8'd2, blue: 8'd2, depth: 16'd1,
                      column: 12'd1, row: 12'd1});
        drain();

        // maximum scale, focal lengths and center y; center x zero
        write_reg(bpj_pkg::REG_DEPTH_SCALE, 16'hFFFF);
        write_reg(bpj_pkg::REG_FOCAL_X, 16'hFFFF);
        write_reg(bpj_pkg::REG_FOCAL_Y, 16'hFFFF);
        write_reg(bpj_pkg::REG_CENTER_X, 16'd0);
        write_reg(bpj_pkg::REG_CENTER_Y, 16'hFFFF);
        for (int i = 0; i < 6; i++) queue_pixel(rand_pixel(1));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (ph == 0) begin
                write_reg(bpj_pkg::REG_DEPTH_SCALE, bpj_pkg::RST_DEPTH_SCALE);
                write_reg(bpj_pkg::REG_FOCAL_X, bpj_pkg::RST_FOCAL_X);
                write_reg(bpj_pkg::REG_FOCAL_Y, bpj_pkg::RST_FOCAL_Y);
                write_reg(bpj_pkg::REG_CENTER_X, bpj_pkg::RST_CENTER_X);
                write_reg(bpj_pkg::REG_CENTER_Y, bpj_pkg::RST_CENTER_Y);
            end else begin
                write_reg(bpj_pkg::REG_DEPTH_SCALE, 16'($urandom_range(1, 65535)));
                write_reg(bpj_pkg::REG_FOCAL_X, 16'($urandom_range(16, 65535)));
                write_reg(bpj_pkg::REG_FOCAL_Y, 16'($urandom_range(16, 65535)));
                write_reg(bpj_pkg::REG_CENTER_X, 16'($urandom));
                write_reg(bpj_pkg::REG_CENTER_Y, 16'($urandom));
            end
            for (int i = 0; i < 50; i++) begin
                // hold off once until the pipeline is empty
                if (ph == 3 && i == 25)
                    wait (pixel_q.size() == 0 && point_q.size() == 0);
                queue_pixel(rand_pixel(1));
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
